/* rtl/fhh_pkg.sv */
// Package for the frequency histogram with halving decay.
// Holds the payload structs, field widths, count limits and register indexes.
// Depends on nothing; fhh_div, the top level and the testbench use it by scoped names.
package fhh_pkg;

  // Field widths of the transfers.
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned CPU_W      = 6;
  localparam int unsigned BIN_IDX_W  = 7;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Count limits: a bin at its maximum triggers the halving walk, after
  // which that bin holds half the maximum plus one.
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_REFILL  = 16'h8000;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_REG_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_HIGH = 2'd1;
  localparam logic [FREQ_W-1:0]    LOW_RESET    = 24'd0;
  localparam logic [FREQ_W-1:0]    HIGH_RESET   = 24'd4000000;

  // One input sample.
  typedef struct packed {
    logic [CPU_W-1:0]  cpu_index;
    logic [FREQ_W-1:0] freq_khz;
  } in_t;

  // One result.
  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [COUNT_W-1:0]   bin_count;
    logic                 halved;
    logic [FREQ_W-1:0]    cpu_peak_khz;
  } out_t;

endpackage

/* rtl/fhh_ram.sv */
// Simple dual-port memory of the frequency histogram: one write and one read
// port, read data registered. Used for the bin counts and the per-CPU peaks.
// Depends on nothing.
module fhh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; the controller never reads beyond DEPTH.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fhh_div.sv */
// Shared compare-and-subtract unit of the frequency histogram: a restoring
// divider that forms one quotient bit a cycle for the rounded bin number.
// Depends on fhh_pkg for the frequency width.
module fhh_div #(
  parameter int unsigned QW = 8,
  parameter int unsigned NW = 31
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NW-1:0]             num_i,
  input  logic [fhh_pkg::FREQ_W-1:0] den_i,
  output logic [QW-1:0]             quot_o,
  output logic                      done_o
);

  // The dividend is 2*num + den, the divisor 2*den; the quotient fits QW bits.
  localparam int unsigned RW = NW + 2;
  localparam int unsigned CW = $clog2(QW);

  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] dsh_q, dsh_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [RW:0]   trial;
  logic          fits;

  // One subtractor serves as both the compare and the subtract.
  assign trial = {1'b0, rem_q} - {1'b0, dsh_q};
  assign fits  = ~trial[RW];

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i, 1'b0} + RW'(den_i);
      dsh_d  = RW'(den_i) << QW;
      quot_d = '0;
      cnt_d  = CW'(QW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? trial[RW-1:0] : rem_q;
      quot_d = {quot_q[QW-2:0], fits};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

/* rtl/frequency_histogram_halving.sv */
// Top level of the frequency histogram with halving decay: sequencer, config
// registers, result register. Depends on fhh_pkg, fhh_ram and fhh_div.
//
// After reset the block clears both memories, one entry a cycle, with busy
// high until the clearing pass ends. A sample is taken when start is high and
// busy is low; busy then stays high until the result is out. A sample that
// lands at or below the low limit, or at or beyond the high one, goes
// straight to the first or last bin; one that needs the bin number worked
// out waits for the divider, which forms one quotient bit a cycle. When the
// chosen bin is full, every bin is halved by a walk through the histogram
// memory at one bin a cycle. The result is shown for exactly one cycle with
// res_valid_o and cannot be held off by the receiver. Configuration writes
// are always ready and take effect at once; the user must make them only
// while the block is idle, and the block itself does not enforce this.
module frequency_histogram_halving #(
  parameter int unsigned BIN_COUNT = 128,
  parameter int unsigned CPU_COUNT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  fhh_pkg::in_t                   in_i,
  output logic                           res_valid_o,
  output fhh_pkg::out_t                  res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fhh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fhh_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FW        = fhh_pkg::FREQ_W;
  localparam int unsigned BW        = $clog2(BIN_COUNT);
  localparam int unsigned QW        = BW + 1;
  localparam int unsigned NUMW      = FW + BW;
  localparam int unsigned CAW       = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int unsigned MAX_DEPTH = (BIN_COUNT > CPU_COUNT) ? BIN_COUNT : CPU_COUNT;
  localparam int unsigned LW        = $clog2(MAX_DEPTH);
  localparam logic [BW-1:0] BIN_LAST = BW'(BIN_COUNT - 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PREP  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_SEL   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_RD    = 9'b001000000,
    S_CHK   = 9'b010000000,
    S_HALVE = 9'b100000000
  } state_e;

  state_e                       state_q, state_d;
  logic [LW-1:0]                clr_cnt_q, clr_cnt_d;
  logic [fhh_pkg::CPU_W-1:0]    cpu_q, cpu_d;
  logic [FW-1:0]                freq_q, freq_d;
  logic [FW-1:0]                peak_q, peak_d;
  logic [FW-1:0]                diff_q, diff_d;
  logic [FW-1:0]                den_q, den_d;
  logic                         zero_q, zero_d;
  logic                         clamp_q, clamp_d;
  logic [NUMW-1:0]              num_q, num_d;
  logic [BW-1:0]                bin_q, bin_d;
  logic [BW-1:0]                rd_ptr_q, rd_ptr_d;
  logic [BW-1:0]                wr_ptr_q, wr_ptr_d;
  logic                         rd_more_q, rd_more_d;
  logic                         wr_pend_q, wr_pend_d;
  fhh_pkg::out_t                res_q, res_d;
  logic                         res_valid_q, res_valid_d;
  logic [FW-1:0]                low_q, high_q;

  logic                         h_we, h_re;
  logic [BW-1:0]                h_waddr, h_raddr;
  logic [fhh_pkg::COUNT_W-1:0]  h_wdata, h_rdata;
  logic                         p_we, p_re;
  logic [CAW-1:0]               p_waddr, p_raddr;
  logic [FW-1:0]                p_wdata, p_rdata;

  logic                         div_start, div_done;
  logic [QW-1:0]                div_quot;
  logic                         cpu_ok;
  logic [FW-1:0]                peak_max;
  logic [fhh_pkg::COUNT_W-1:0]  count_inc;

  // Bin counts and per-CPU peaks.
  fhh_ram #(
    .WIDTH (fhh_pkg::COUNT_W),
    .DEPTH (BIN_COUNT),
    .AW    (BW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  fhh_ram #(
    .WIDTH (FW),
    .DEPTH (CPU_COUNT),
    .AW    (CAW)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Divider for the rounded bin number.
  fhh_div #(
    .QW (QW),
    .NW (NUMW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  assign cpu_ok    = (32'(cpu_q) < CPU_COUNT);
  assign peak_max  = (freq_q > p_rdata) ? freq_q : p_rdata;
  assign count_inc = h_rdata + 1'b1;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cpu_d       = cpu_q;
    freq_d      = freq_q;
    peak_d      = peak_q;
    diff_d      = diff_q;
    den_d       = den_q;
    zero_d      = zero_q;
    clamp_d     = clamp_q;
    num_d       = num_q;
    bin_d       = bin_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    rd_more_d   = rd_more_q;
    wr_pend_d   = wr_pend_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    h_we        = 1'b0;
    h_waddr     = '0;
    h_wdata     = '0;
    h_re        = 1'b0;
    h_raddr     = '0;
    p_we        = 1'b0;
    p_waddr     = '0;
    p_wdata     = '0;
    p_re        = 1'b0;
    p_raddr     = '0;
    div_start   = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        // Clearing pass over both memories after reset.
        if (32'(clr_cnt_q) < BIN_COUNT) begin
          h_we    = 1'b1;
          h_waddr = BW'(clr_cnt_q);
        end
        if (32'(clr_cnt_q) < CPU_COUNT) begin
          p_we    = 1'b1;
          p_waddr = CAW'(clr_cnt_q);
        end
        if (32'(clr_cnt_q) == MAX_DEPTH - 1) begin
          state_d = S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cpu_d   = in_i.cpu_index;
          freq_d  = in_i.freq_khz;
          p_re    = 1'b1;
          p_raddr = CAW'(in_i.cpu_index);
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        // Peak update and the offsets from the low limit.
        if (cpu_ok) begin
          p_we    = 1'b1;
          p_waddr = CAW'(cpu_q);
          p_wdata = peak_max;
          peak_d  = peak_max;
        end else begin
          peak_d  = freq_q;
        end
        diff_d  = freq_q - low_q;
        den_d   = high_q - low_q;
        zero_d  = (high_q <= low_q) || (freq_q <= low_q);
        state_d = S_MUL;
      end
      S_MUL: begin
        num_d   = NUMW'(diff_q) * NUMW'(BIN_COUNT);
        clamp_d = (diff_q >= den_q);
        state_d = S_SEL;
      end
      S_SEL: begin
        // At or below the low limit goes to the first bin, at or past the high one to the last.
        if (zero_q) begin
          bin_d   = '0;
          state_d = S_RD;
        end else if (clamp_q) begin
          bin_d   = BIN_LAST;
          state_d = S_RD;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          bin_d   = (32'(div_quot) > BIN_COUNT - 1) ? BIN_LAST : div_quot[BW-1:0];
          state_d = S_RD;
        end
      end
      S_RD: begin
        h_re    = 1'b1;
        h_raddr = bin_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (h_rdata == fhh_pkg::COUNT_MAX) begin
          rd_ptr_d  = '0;
          rd_more_d = 1'b1;
          wr_pend_d = 1'b0;
          state_d   = S_HALVE;
        end else begin
          h_we               = 1'b1;
          h_waddr            = bin_q;
          h_wdata            = count_inc;
          res_d.bin_index    = fhh_pkg::BIN_IDX_W'(bin_q);
          res_d.bin_count    = count_inc;
          res_d.halved       = 1'b0;
          res_d.cpu_peak_khz = peak_q;
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_HALVE: begin
        // Reads run one bin ahead of the halved write-back.
        if (rd_more_q) begin
          h_re     = 1'b1;
          h_raddr  = rd_ptr_q;
          rd_ptr_d = rd_ptr_q + 1'b1;
          if (rd_ptr_q == BIN_LAST) begin
            rd_more_d = 1'b0;
          end
        end
        wr_pend_d = rd_more_q;
        wr_ptr_d  = rd_ptr_q;
        if (wr_pend_q) begin
          h_we    = 1'b1;
          h_waddr = wr_ptr_q;
          h_wdata = (wr_ptr_q == bin_q) ? fhh_pkg::COUNT_REFILL : (h_rdata >> 1);
        end
        if (!rd_more_q && wr_pend_q) begin
          res_d.bin_index    = fhh_pkg::BIN_IDX_W'(bin_q);
          res_d.bin_count    = fhh_pkg::COUNT_REFILL;
          res_d.halved       = 1'b1;
          res_d.cpu_peak_khz = peak_q;
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      rd_more_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
      low_q       <= fhh_pkg::LOW_RESET;
      high_q      <= fhh_pkg::HIGH_RESET;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rd_more_q   <= rd_more_d;
      wr_pend_q   <= wr_pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          fhh_pkg::CFG_REG_LOW:  low_q  <= cfg_data_i;
          fhh_pkg::CFG_REG_HIGH: high_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Sample, working values and the result register.
  always_ff @(posedge clk_i) begin
    cpu_q    <= cpu_d;
    freq_q   <= freq_d;
    peak_q   <= peak_d;
    diff_q   <= diff_d;
    den_q    <= den_d;
    zero_q   <= zero_d;
    clamp_q  <= clamp_d;
    num_q    <= num_d;
    bin_q    <= bin_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    res_q    <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  // A sample transfer makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after a sample transfer");

  // The result strobe lasts a single cycle.
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for more than one cycle");

  // A halved result always reports the refilled count.
  a_halved_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.halved |-> res_o.bin_count == fhh_pkg::COUNT_REFILL)
    else $error("halved result with wrong count");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  // The chosen bin is always inside the histogram.
  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> 32'(bin_q) < BIN_COUNT)
    else $error("bin number beyond the histogram");
`endif

endmodule

/* bench/frequency_histogram_halving_tb.sv */
// Self-checking testbench for frequency_histogram_halving: a directed table, then
// random phases over several range settings and a tail under the reset range.
// Depends on fhh_pkg and the block's RTL only.
module frequency_histogram_halving_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FREQ_W       = fhh_pkg::FREQ_W;
  localparam int unsigned CPU_W        = fhh_pkg::CPU_W;
  localparam int unsigned BIN_IDX_W    = fhh_pkg::BIN_IDX_W;
  localparam int unsigned COUNT_W      = fhh_pkg::COUNT_W;
  localparam int unsigned CFG_IDX_W    = fhh_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W   = fhh_pkg::CFG_DATA_W;
  localparam int unsigned BINS         = 128;
  localparam int unsigned CPUS         = 64;
  localparam int unsigned BIN_AW       = $clog2(BINS);
  localparam int unsigned FREQ_MAX     = (1 << FREQ_W) - 1;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned TAIL_ITEMS   = 60;
  localparam int unsigned DRAIN_CYCLES = 2 * (BINS + 1) + 40;
  localparam int unsigned REPORT_LIMIT = 10;

  // Register indexes, reset values and the count limit of the block.
  localparam logic [CFG_IDX_W-1:0] CFG_REG_LOW  = fhh_pkg::CFG_REG_LOW;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_HIGH = fhh_pkg::CFG_REG_HIGH;
  localparam logic [FREQ_W-1:0]    LOW_RESET    = fhh_pkg::LOW_RESET;
  localparam logic [FREQ_W-1:0]    HIGH_RESET   = fhh_pkg::HIGH_RESET;
  localparam logic [COUNT_W-1:0]   COUNT_MAX    = fhh_pkg::COUNT_MAX;

  // Register indexes past the end of the list; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_SPARE3 = 2'd3;

  typedef enum logic [0:0] {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  // One line of the directed plan: a register write or a sample, with an
  // optional hand-worked result.
  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [FREQ_W-1:0]     value;
    logic [CPU_W-1:0]      cpu;
    bit                    typed;
    fhh_pkg::out_t         want;
  } plan_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  fhh_pkg::in_t          in_i        = '0;
  logic                  res_valid_o;
  fhh_pkg::out_t         res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Shadow state of the histogram, the per-CPU peaks and the range registers.
  logic [COUNT_W-1:0] hist_model [BINS];
  logic [FREQ_W-1:0]  peak_model [CPUS];
  logic [FREQ_W-1:0]  model_low_khz;
  logic [FREQ_W-1:0]  model_high_khz;

  fhh_pkg::out_t expected_results [$];
  int unsigned   fail_count = 0;
  plan_row_t     plan [$];

  frequency_histogram_halving #(
    .BIN_COUNT(BINS),
    .CPU_COUNT(CPUS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Raises the CPU peak, picks the bin, halves every bin if the chosen one is
  // full, then counts the sample. Returns the result the block should give.
  function automatic fhh_pkg::out_t predict_sample(fhh_pkg::in_t s);
    fhh_pkg::out_t     r;
    logic [63:0]       num;
    logic [63:0]       den;
    logic [63:0]       quo;
    logic [BIN_AW-1:0] bin_no;
    logic [FREQ_W-1:0] peak;
    peak = s.freq_khz;
    if (32'(s.cpu_index) < CPUS) begin
      if (s.freq_khz > peak_model[s.cpu_index]) peak_model[s.cpu_index] = s.freq_khz;
      peak = peak_model[s.cpu_index];
    end
    // Round half up of the scaled offset; anything at or below low lands in bin 0.
    if (model_high_khz <= model_low_khz || s.freq_khz <= model_low_khz) begin
      bin_no = '0;
    end else begin
      num = {40'd0, s.freq_khz - model_low_khz} * 64'(BINS);
      den = {40'd0, model_high_khz - model_low_khz};
      quo = (2 * num + den) / (2 * den);
      bin_no = (quo > 64'(BINS - 1)) ? BIN_AW'(BINS - 1) : quo[BIN_AW-1:0];
    end
    r.halved = 1'b0;
    if (hist_model[bin_no] == COUNT_MAX) begin
      foreach (hist_model[j]) hist_model[j] = hist_model[j] >> 1;
      r.halved = 1'b1;
    end
    hist_model[bin_no] = hist_model[bin_no] + 1'b1;
    r.bin_index    = BIN_IDX_W'(bin_no);
    r.bin_count    = hist_model[bin_no];
    r.cpu_peak_khz = peak;
    return r;
  endfunction

  // A frequency spread over the current range, with its edges, points near
  // low and the full 24-bit span mixed in.
  function automatic logic [FREQ_W-1:0] draw_freq();
    int unsigned lo_k;
    int unsigned hi_k;
    int unsigned span;
    int unsigned pick;
    lo_k = (model_low_khz < model_high_khz) ? 32'(model_low_khz) : 32'(model_high_khz);
    hi_k = (model_low_khz < model_high_khz) ? 32'(model_high_khz) : 32'(model_low_khz);
    case ($urandom_range(0, 9))
      0, 1: pick = $urandom_range(0, FREQ_MAX);
      2: pick = 32'(model_low_khz);
      3: pick = 32'(model_high_khz);
      4: pick = (lo_k >= 4) ? lo_k - 4 + $urandom_range(0, 8) : $urandom_range(0, 8);
      default: begin
        span = hi_k - lo_k + 1;
        pick = lo_k + $urandom_range(0, span + span / 8);
      end
    endcase
    if (pick > FREQ_MAX) pick = FREQ_MAX;
    return pick[FREQ_W-1:0];
  endfunction

  // Compares one result with the oldest expectation, field by field.
  function automatic void check_result(fhh_pkg::out_t got);
    fhh_pkg::out_t want;
    bit            bad;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("unexpected result: bin %0d count %0d halved %0b peak %0d",
                 got.bin_index, got.bin_count, got.halved, got.cpu_peak_khz);
      return;
    end
    want = expected_results.pop_front();
    bad = (got.bin_index != want.bin_index) || (got.bin_count != want.bin_count) ||
          (got.halved != want.halved) || (got.cpu_peak_khz != want.cpu_peak_khz);
    if (bad) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("mismatch: expected bin %0d count %0d halved %0b peak %0d",
                 want.bin_index, want.bin_count, want.halved, want.cpu_peak_khz);
        $display("          got bin %0d count %0d halved %0b peak %0d",
                 got.bin_index, got.bin_count, got.halved, got.cpu_peak_khz);
      end
    end
  endfunction

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) check_result(res_o);
  end

  // Offers one sample after an optional gap and holds it until the transfer.
  // Start is left high so that a back-to-back sample needs no second assignment.
  task automatic send_sample(fhh_pkg::in_t s, bit typed, fhh_pkg::out_t want,
                             int unsigned gap);
    fhh_pkg::out_t predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= s;
    do @(posedge clk_i); while (busy);
    predicted = predict_sample(s);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Lets the block finish everything in flight before a register write.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0 || busy);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REG_LOW:  model_low_khz  = value;
      CFG_REG_HIGH: model_high_khz = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Picks a range setting for one random phase; every kind comes round in turn.
  task automatic set_range(int unsigned mode);
    int unsigned lo_k;
    int unsigned hi_k;
    case (mode)
      0: begin
        lo_k = $urandom_range(0, 2000000);
        hi_k = lo_k + $urandom_range(1, 4000000);
      end
      1: begin
        lo_k = $urandom_range(0, FREQ_MAX);
        hi_k = $urandom_range(0, FREQ_MAX);
      end
      2: begin
        lo_k = $urandom_range(0, 16000000);
        hi_k = lo_k + $urandom_range(1, 300);
      end
      3: begin
        lo_k = 0;
        hi_k = FREQ_MAX;
      end
      4: begin
        lo_k = $urandom_range(1, FREQ_MAX);
        hi_k = $urandom_range(0, lo_k);
      end
      default: begin
        lo_k = 32'(LOW_RESET);
        hi_k = 32'(HIGH_RESET);
      end
    endcase
    settle();
    write_register(CFG_REG_LOW, lo_k[FREQ_W-1:0]);
    write_register(CFG_REG_HIGH, hi_k[FREQ_W-1:0]);
  endtask

  initial begin
    #(40_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    fhh_pkg::in_t s;
    bit           idle_on;
    int unsigned  gap;
    foreach (hist_model[i]) hist_model[i] = '0;
    foreach (peak_model[i]) peak_model[i] = '0;
    model_low_khz  = LOW_RESET;
    model_high_khz = HIGH_RESET;

    // Directed plan under the reset range 0 .. 4000000 kHz, then edge settings.
    plan = '{
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd0,        6'd0,  1'b1, '{7'd0,   16'd1, 1'b0, 24'd0}},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'hFFFFFF,   6'd63, 1'b1,
        '{7'd127, 16'd1, 1'b0, 24'hFFFFFF}},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd0,        6'd63, 1'b1,
        '{7'd0,   16'd2, 1'b0, 24'hFFFFFF}},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd4000000,  6'd5,  1'b1,
        '{7'd127, 16'd2, 1'b0, 24'd4000000}},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd2000000,  6'd5,  1'b1,
        '{7'd64,  16'd1, 1'b0, 24'd4000000}},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd15625,    6'd1,  1'b1, '{7'd1, 16'd1, 1'b0, 24'd15625}},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd15624,    6'd1,  1'b1, '{7'd0, 16'd3, 1'b0, 24'd15625}},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd1000000,  6'd2,  1'b1,
        '{7'd32,  16'd1, 1'b0, 24'd1000000}},
      '{ROW_WRITE,  CFG_REG_LOW,    24'd1000000,  6'd0,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd999999,   6'd2,  1'b1,
        '{7'd0,   16'd4, 1'b0, 24'd1000000}},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd1000000,  6'd2,  1'b1,
        '{7'd0,   16'd5, 1'b0, 24'd1000000}},
      '{ROW_WRITE,  CFG_REG_SPARE2, 24'h123456,   6'd0,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_SPARE3, 24'hFFFFFF,   6'd0,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd1000001,  6'd3,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd2500000,  6'd3,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_HIGH,   24'd1000000,  6'd0,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'hFFFFFF,   6'd4,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_HIGH,   24'd999999,   6'd0,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd500000,   6'd4,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_LOW,    24'd0,        6'd0,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_HIGH,   24'hFFFFFF,   6'd0,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'hFFFFFF,   6'd7,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd1,        6'd7,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_LOW,    24'hFFFFFF,   6'd0,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_HIGH,   24'd0,        6'd0,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'hFFFFFF,   6'd8,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_LOW,    24'd0,        6'd0,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_HIGH,   24'd1,        6'd0,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd1,        6'd9,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd0,        6'd9,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_HIGH,   24'd2,        6'd0,  1'b0, '0},
      '{ROW_SAMPLE, CFG_REG_LOW,    24'd1,        6'd10, 1'b0, '0},
      '{ROW_WRITE,  CFG_REG_LOW,    LOW_RESET,    6'd0,  1'b0, '0},
      '{ROW_WRITE,  CFG_REG_HIGH,   HIGH_RESET,   6'd0,  1'b0, '0}
    };

    // Reset, then wait out the clearing pass.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_register(plan[i].reg_index, plan[i].value);
      end else begin
        s.cpu_index = plan[i].cpu;
        s.freq_khz  = plan[i].value;
        send_sample(s, plan[i].typed, plan[i].want, $urandom_range(0, 15));
      end
    end

    // Random phases, one range kind each; every third phase runs without gaps.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      set_range(phase);
      idle_on = (phase % 3 != 2);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        s.cpu_index = ($urandom_range(0, 3) == 0) ? CPU_W'($urandom_range(0, 3))
                                                  : CPU_W'($urandom_range(0, CPUS - 1));
        s.freq_khz  = draw_freq();
        gap = idle_on ? $urandom_range(0, 15) : 0;
        send_sample(s, 1'b0, '0, gap);
      end
    end

    // Spread samples over the reset range on top of the counts built so far.
    set_range(5);
    for (int unsigned n = 0; n < TAIL_ITEMS; n++) begin
      s.cpu_index = CPU_W'($urandom_range(0, CPUS - 1));
      s.freq_khz  = draw_freq();
      send_sample(s, 1'b0, '0, $urandom_range(0, 15));
    end

    // Drain and give any stray result time to show.
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
